>>> hw/rtl/b64d_pkg.sv
`timescale 1ns / 1ps
// Shared types, class codes and the character classifier for the base64 decoder.
// Depends on nothing. It is imported by every other file of the block.
package b64d_pkg;

  // Class codes returned by the classifier. Values below 64 are sextets.
  localparam logic [7:0] CLS_PAD  = 8'h40;
  localparam logic [7:0] CLS_SKIP = 8'h4F;
  localparam logic [7:0] CLS_BAD  = 8'h80;

  // One decoded result item as it travels to the output register.
  typedef struct packed {
    logic [7:0] data_byte;
    logic       byte_valid;
    logic       message_end;
    logic       decode_error;
  } b64d_result_t;

  // Maps a raw character to its sextet or to one of the class codes.
  function automatic logic [7:0] classify(input logic [7:0] c);
    logic [7:0] cls;
    cls = CLS_BAD;
    if (c >= 8'h41 && c <= 8'h5A) begin
      cls = c - 8'h41;
    end else if (c >= 8'h61 && c <= 8'h7A) begin
      cls = c - 8'h61 + 8'd26;
    end else if (c >= 8'h30 && c <= 8'h39) begin
      cls = c - 8'h30 + 8'd52;
    end else if (c == 8'h2B) begin
      cls = 8'd62;
    end else if (c == 8'h2F) begin
      cls = 8'd63;
    end else if (c == 8'h3D) begin
      cls = CLS_PAD;
    end else if (c == 8'h0D || c == 8'h0A) begin
      cls = CLS_SKIP;
    end
    return cls;
  endfunction

endpackage

>>> hw/rtl/b64d_in_reg.sv
`timescale 1ns / 1ps
// Input register stage of the base64 decoder: holds one character transaction.
// Depends on b64d_pkg.
module b64d_in_reg
  import b64d_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  logic       s_tvalid,
  output logic       s_tready,
  input  logic [7:0] s_tdata,
  input  logic       s_tlast,
  input  logic       take,
  output logic       valid,
  output logic [7:0] ch,
  output logic       last_char
);

  logic valid_next;

  assign s_tready   = !valid || take;
  assign valid_next = (s_tvalid && s_tready) || (valid && !take);

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else begin
      valid <= valid_next;
    end
  end

  always_ff @(posedge clk) begin
    if (s_tvalid && s_tready) begin
      ch        <= s_tdata;
      last_char <= s_tlast;
    end
  end

endmodule

>>> hw/rtl/b64d_core.sv
`timescale 1ns / 1ps
// Decoding core: group position, previous sextet and padding phase, with the
// logic that turns one registered character into at most one result. Uses b64d_pkg.
module b64d_core
  import b64d_pkg::*;
(
  input  logic         clk,
  input  logic         rst,
  input  logic         valid,
  input  logic [7:0]   ch,
  input  logic         last_char,
  input  logic         out_free,
  output logic         take,
  output logic         res_load,
  output b64d_result_t res
);

  localparam logic [1:0] PH_DATA = 2'd0;
  localparam logic [1:0] PH_PAD1 = 2'd1;
  localparam logic [1:0] PH_DONE = 2'd2;
  localparam logic [1:0] PH_ERR  = 2'd3;

  logic [1:0] group_pos, group_pos_next;
  logic [5:0] prev_sextet, prev_sextet_next;
  logic [1:0] phase, phase_next;
  logic [7:0] cls;
  logic       is_data;
  logic       have_byte;
  logic [7:0] byte_val;
  logic       has_result;
  logic       bad;

  assign cls     = classify(ch);
  assign is_data = (cls[7:6] == 2'b00);

  always_comb begin
    group_pos_next   = group_pos;
    prev_sextet_next = prev_sextet;
    phase_next       = phase;
    have_byte        = 1'b0;
    byte_val         = 8'd0;
    unique case (phase)
      PH_DATA: begin
        if (is_data) begin
          case (group_pos)
            2'd0: have_byte = 1'b0;
            2'd1: begin
              byte_val  = {prev_sextet, cls[5:4]};
              have_byte = 1'b1;
            end
            2'd2: begin
              byte_val  = {prev_sextet[3:0], cls[5:2]};
              have_byte = 1'b1;
            end
            default: begin
              byte_val  = {prev_sextet[1:0], cls[5:0]};
              have_byte = 1'b1;
            end
          endcase
          prev_sextet_next = cls[5:0];
          group_pos_next   = group_pos + 2'd1;
        end else if (cls == CLS_PAD) begin
          if (group_pos == 2'd2) begin
            phase_next = PH_PAD1;
          end else if (group_pos == 2'd3) begin
            phase_next = PH_DONE;
          end else begin
            phase_next = PH_ERR;
          end
        end else if (cls != CLS_SKIP) begin
          phase_next = PH_ERR;
        end
      end
      PH_PAD1: begin
        if (cls == CLS_PAD) begin
          phase_next = PH_DONE;
        end else if (cls != CLS_SKIP) begin
          phase_next = PH_ERR;
        end
      end
      PH_DONE: begin
        if (cls != CLS_SKIP) begin
          phase_next = PH_ERR;
        end
      end
      default: phase_next = PH_ERR;
    endcase
  end

  // The end-of-message verdict looks at the state as this character leaves it.
  assign bad = (phase_next == PH_ERR) || (phase_next == PH_PAD1) ||
               (phase_next == PH_DATA && group_pos_next != 2'd0);

  assign has_result = have_byte || last_char;
  assign take       = valid && (!has_result || out_free);
  assign res_load   = take && has_result;

  assign res.data_byte    = byte_val;
  assign res.byte_valid   = have_byte;
  assign res.message_end  = last_char;
  assign res.decode_error = last_char && bad;

  always_ff @(posedge clk) begin
    if (rst) begin
      group_pos   <= 2'd0;
      prev_sextet <= 6'd0;
      phase       <= PH_DATA;
    end else if (take) begin
      if (last_char) begin
        group_pos   <= 2'd0;
        prev_sextet <= 6'd0;
        phase       <= PH_DATA;
      end else begin
        group_pos   <= group_pos_next;
        prev_sextet <= prev_sextet_next;
        phase       <= phase_next;
      end
    end
  end

endmodule

>>> hw/rtl/b64d_out_reg.sv
`timescale 1ns / 1ps
// Output register of the base64 decoder: holds one result transaction until taken.
// Depends on b64d_pkg for the result type.
module b64d_out_reg
  import b64d_pkg::*;
(
  input  logic         clk,
  input  logic         rst,
  input  logic         load,
  input  b64d_result_t res,
  output logic         out_free,
  output logic         m_tvalid,
  input  logic         m_tready,
  output logic [7:0]   m_tdata,
  output logic         m_tlast,
  output logic [1:0]   m_tuser
);

  b64d_result_t held;
  logic         m_tvalid_next;

  assign out_free      = !m_tvalid || m_tready;
  assign m_tvalid_next = load || (m_tvalid && !m_tready);

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else begin
      m_tvalid <= m_tvalid_next;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      held <= res;
    end
  end

  assign m_tdata = held.data_byte;
  assign m_tlast = held.message_end;
  assign m_tuser = {held.decode_error, held.byte_valid};

endmodule

>>> hw/rtl/base64_stream_decoder.sv
`timescale 1ns / 1ps
// Top level of the streaming base64 decoder.
// Depends on b64d_pkg, b64d_in_reg, b64d_core and b64d_out_reg.
//
// This block decodes standard base64 text (A-Z a-z 0-9 + / with '=' padding)
// at one character per clock. Each input transaction carries one character
// in s_tdata, with s_tlast marking the final character of a message. CR and
// LF are skipped anywhere. A decoded byte leaves as soon as the second, third
// or fourth character of a four-character group arrives; characters that
// complete no byte and do not end the message produce no output transaction.
// The transaction for the last character always appears, with m_tlast set and
// the final status in m_tuser[1]: 0 for a well-formed message, 1 for a
// malformed one (bad character, misplaced padding, data after padding, or an
// incomplete final group). After an error no further bytes are emitted, and a
// caller that sees the error should discard the bytes of that message. The
// path is an input register, combinational classification and decoding
// against the group state, and an output register. A character's result is
// registered in the output register, and a new character is accepted every
// cycle while the output keeps pace. While a finished result waits in the
// output register, the input register still accepts characters that produce
// no result and passes them through; a character that produces a result stays
// in the input register, and s_tready stays low, until the output register is
// free. All state returns to its reset value after each last character.
module base64_stream_decoder
  import b64d_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  logic       s_tvalid,
  output logic       s_tready,
  input  logic [7:0] s_tdata,  // [7:0] ch
  input  logic       s_tlast,  // last_char
  output logic       m_tvalid,
  input  logic       m_tready,
  output logic [7:0] m_tdata,  // [7:0] data_byte
  output logic       m_tlast,  // message_end
  output logic [1:0] m_tuser   // [0] byte_valid, [1] decode_error
);

  logic         in_valid;
  logic [7:0]   in_ch;
  logic         in_last;
  logic         take;
  logic         res_load;
  logic         out_free;
  b64d_result_t res;

  // Input stage: one character waits here while the core decides on it.
  b64d_in_reg u_in_reg (
    .clk       (clk),
    .rst       (rst),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .s_tdata   (s_tdata),
    .s_tlast   (s_tlast),
    .take      (take),
    .valid     (in_valid),
    .ch        (in_ch),
    .last_char (in_last)
  );

  // The core consumes a character when it yields no result, or when the
  // output register can take the result in the same cycle.
  b64d_core u_core (
    .clk       (clk),
    .rst       (rst),
    .valid     (in_valid),
    .ch        (in_ch),
    .last_char (in_last),
    .out_free  (out_free),
    .take      (take),
    .res_load  (res_load),
    .res       (res)
  );

  b64d_out_reg u_out_reg (
    .clk      (clk),
    .rst      (rst),
    .load     (res_load),
    .res      (res),
    .out_free (out_free),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tlast  (m_tlast),
    .m_tuser  (m_tuser)
  );

endmodule
